@@ rtl/core/obsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package obsl_pkg;
   localparam int BookDepthDefault = 16;
   localparam int ExchangesDefault = 4;
   localparam int QtyW = 32;
   localparam int PriceW = 32;
   localparam int SumW = 34;
   localparam int MaxOut = 16;
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_UPDATED = 3'd2;
   localparam logic [2:0] ST_CLEARED = 3'd3;
   localparam logic [2:0] ST_REMOVED = 3'd4;
   localparam logic [2:0] ST_PAST_END = 3'd5;
   localparam logic [2:0] ST_ROW = 3'd6;
   localparam logic [2:0] ST_EMPTY = 3'd7;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_APPLY, S_RESULT, S_READ, S_READ_WAIT
   } state_type;

   typedef struct packed {
      logic capture;    // latch input item, compute location
      logic apply;      // perform update on the table
      logic read_start; // reset read pointer
      logic read_step;  // present row at pointer, advance
   } cmd_type;

   typedef struct packed {
      logic read_done;  // pointer is at the last row to read, or the read count is zero
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/core/obsl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module obsl_ctrl
   import obsl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic in_op,
   output logic      in_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   output cmd_type   cmd,
   input  stat_type  stat
);
   state_type state_ff, state_in;
   logic op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_UPDATE;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in = in_op;
               state_in = S_APPLY;
            end
         end
         S_APPLY: state_in = (op_ff == OP_READ) ? S_READ : S_RESULT;
         S_RESULT: if (out_ready) state_in = S_IDLE;
         S_READ: if (out_ready && stat.read_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      in_ready = 1'b0;
      out_valid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            cmd.capture = in_valid;
         end
         S_APPLY: begin
            cmd.apply = (op_ff == OP_UPDATE);
            cmd.read_start = (op_ff == OP_READ);
         end
         S_RESULT: out_valid = 1'b1;
         S_READ: begin
            out_valid = 1'b1;
            cmd.read_step = out_ready;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/obsl_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module obsl_datapath
   import obsl_pkg::*;
#(
   parameter int BOOK_DEPTH = BookDepthDefault,
   parameter int EXCHANGES = ExchangesDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     desc,
   input  wire logic [PriceW-1:0]        in_price,
   input  wire logic [QtyW-1:0]          in_qty,
   input  wire logic [1:0]               in_exch,
   input  wire logic [4:0]               in_limit,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   output logic [2:0]                    o_status,
   output logic [PriceW-1:0]             o_price,
   output logic [SumW-1:0]               o_total,
   output logic [3:0][QtyW-1:0]          o_qty,
   output logic                          o_last
);
   localparam int IW = $clog2(BOOK_DEPTH);
   localparam int CW = $clog2(BOOK_DEPTH + 1);
   localparam int EW = (EXCHANGES > 1) ? $clog2(EXCHANGES) : 1;

   logic [PriceW-1:0] price_ff [BOOK_DEPTH];
   logic [EXCHANGES-1:0][QtyW-1:0] qty_ff [BOOK_DEPTH];
   logic [SumW-1:0] sum_ff [BOOK_DEPTH];
   logic [BOOK_DEPTH-1:0] valid_ff;

   // Latched item and search result.
   logic [PriceW-1:0] p_ff;
   logic [QtyW-1:0] q_ff;
   logic ex_bad_ff;
   logic [EW-1:0] ex_ff;
   logic [BOOK_DEPTH-1:0] ge_ff;   // per row: row is at or past the target
   logic [CW-1:0] cnt_ff, cnt_in;  // read count
   logic [CW-1:0] rp_ff;

   // Update result register.
   logic [2:0] res_status_ff;
   logic [PriceW-1:0] res_price_ff;
   logic [SumW-1:0] res_total_ff;
   logic [3:0][QtyW-1:0] res_qty_ff;
   logic res_last_ff;

   // Per-row compare: a row stops the search if invalid or not better.
   logic [BOOK_DEPTH-1:0] stop;
   always_comb begin
      for (int r = 0; r < BOOK_DEPTH; r++) begin
         stop[r] = !valid_ff[r] ||
            !(desc ? (price_ff[r] > in_price) : (price_ff[r] < in_price));
      end
   end

   // The first stop wins; a table left unsorted by a side switch can stop again later.
   logic [BOOK_DEPTH-1:0] ge;
   always_comb begin
      ge[0] = stop[0];
      for (int r = 1; r < BOOK_DEPTH; r++) ge[r] = ge[r-1] | stop[r];
   end

   // Read count: number of leading valid rows capped by the limit.
   logic [4:0] lim;
   always_comb begin
      lim = (in_limit > 5'(MaxOut)) ? 5'(MaxOut) : in_limit;
      if (32'(lim) > BOOK_DEPTH) lim = 5'(BOOK_DEPTH);
   end

   logic [CW-1:0] nvalid;
   always_comb begin
      nvalid = '0;
      for (int r = BOOK_DEPTH - 1; r >= 0; r--) begin
         if (!valid_ff[r]) nvalid = CW'(r);
      end
      if (&valid_ff) nvalid = CW'(BOOK_DEPTH);
      cnt_in = (32'(nvalid) < 32'(lim)) ? nvalid : CW'(lim);
   end

   // Target row from the thermometer of stops.
   logic [BOOK_DEPTH-1:0] at;
   logic found;
   logic [IW-1:0] loc;
   always_comb begin
      at = ge_ff & ~(ge_ff << 1);
      found = |ge_ff;
      loc = '0;
      for (int r = 0; r < BOOK_DEPTH; r++) if (at[r]) loc = IW'(r);
   end

   logic match;
   logic [EXCHANGES-1:0][QtyW-1:0] row_new;
   logic [3:0][QtyW-1:0] row_new4;
   logic [SumW-1:0] row_sum;
   logic [SumW+3:0] acc;
   always_comb begin
      match = found && valid_ff[loc] && price_ff[loc] == p_ff;
      row_new = match ? qty_ff[loc] : '0;
      row_new[ex_ff] = q_ff;
      row_new4 = '0;
      for (int j = 0; j < 4; j++) if (j < EXCHANGES) row_new4[j] = row_new[j];
      acc = '0;
      for (int e = 0; e < EXCHANGES; e++) acc = acc + (SumW+4)'(row_new[e]);
      row_sum = (acc > (SumW+4)'(SumMax)) ? SumMax : acc[SumW-1:0];
   end

   logic ins, upd, clr, rem;
   always_comb begin
      ins = !ex_bad_ff && found && !match && q_ff != '0;
      upd = !ex_bad_ff && match && q_ff != '0;
      clr = !ex_bad_ff && match && q_ff == '0 && row_new != '0;
      rem = !ex_bad_ff && match && q_ff == '0 && row_new == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int r = 0; r < BOOK_DEPTH; r++) begin
            qty_ff[r] <= '0;
            sum_ff[r] <= '0;
         end
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.capture) begin
            p_ff <= in_price;
            q_ff <= in_qty;
            ex_bad_ff <= 32'(in_exch) >= EXCHANGES;
            ex_ff <= EW'(in_exch);
            ge_ff <= ge;
            cnt_ff <= cnt_in;
         end
         if (cmd.read_start) rp_ff <= '0;
         if (cmd.read_step) rp_ff <= rp_ff + 1'b1;
         if (cmd.apply) begin
            res_last_ff <= 1'b1;
            res_price_ff <= p_ff;
            res_status_ff <= ex_bad_ff ? ST_IGNORED : !found ? ST_PAST_END :
               ins ? ST_INSERTED : upd ? ST_UPDATED : clr ? ST_CLEARED :
               rem ? ST_REMOVED : ST_IGNORED;
            res_total_ff <= (ins || upd || clr) ? row_sum : '0;
            res_qty_ff <= (ins || upd || clr) ? row_new4 : '0;
            for (int r = 0; r < BOOK_DEPTH; r++) begin
               if (ins) begin
                  if (at[r]) begin
                     valid_ff[r] <= 1'b1;
                     price_ff[r] <= p_ff;
                     qty_ff[r] <= row_new;
                     sum_ff[r] <= row_sum;
                  end else if (r > 0 && ge_ff[r]) begin
                     valid_ff[r] <= valid_ff[r-1];
                     price_ff[r] <= price_ff[r-1];
                     qty_ff[r] <= qty_ff[r-1];
                     sum_ff[r] <= sum_ff[r-1];
                  end
               end else if ((upd || clr) && at[r]) begin
                  qty_ff[r] <= row_new;
                  sum_ff[r] <= row_sum;
               end else if (rem && ge_ff[r]) begin
                  if (r == BOOK_DEPTH - 1) begin
                     valid_ff[r] <= 1'b0;
                     qty_ff[r] <= '0;
                     sum_ff[r] <= '0;
                  end else begin
                     valid_ff[r] <= valid_ff[r+1];
                     price_ff[r] <= price_ff[r+1];
                     qty_ff[r] <= qty_ff[r+1];
                     sum_ff[r] <= sum_ff[r+1];
                  end
               end
            end
         end
      end
   end

   // Read rows come straight from the table at the pointer.
   logic [IW-1:0] ri;
   logic [EXCHANGES-1:0][QtyW-1:0] rq;
   logic [3:0][QtyW-1:0] rq4;
   logic rd_mode_ff;
   always_ff @(posedge clock) begin
      if (reset) rd_mode_ff <= 1'b0;
      else if (cmd.read_start) rd_mode_ff <= 1'b1;
      else if (cmd.apply) rd_mode_ff <= 1'b0;
   end
   always_comb begin
      ri = rp_ff[IW-1:0];
      rq = qty_ff[ri];
      rq4 = '0;
      for (int j = 0; j < 4; j++) if (j < EXCHANGES) rq4[j] = rq[j];
      stat.read_done = (cnt_ff == '0) || (rp_ff + 1'b1 >= cnt_ff);
   end

   // Output view: read rows override the update result register.
   logic [2:0] u_status;
   logic [PriceW-1:0] u_price;
   logic [SumW-1:0] u_total;
   logic [3:0][QtyW-1:0] u_qty;
   logic u_last;
   assign u_status = res_status_ff;
   assign u_price = res_price_ff;
   assign u_total = res_total_ff;
   assign u_qty = res_qty_ff;
   assign u_last = res_last_ff;

   logic [2:0] v_status;
   logic [PriceW-1:0] v_price;
   logic [SumW-1:0] v_total;
   logic [3:0][QtyW-1:0] v_qty;
   logic v_last;
   always_comb begin
      v_status = u_status;
      v_price = u_price;
      v_total = u_total;
      v_qty = u_qty;
      v_last = u_last;
      if (rd_mode_ff) begin
         v_last = stat.read_done;
         if (cnt_ff == '0) begin
            v_status = ST_EMPTY;
            v_price = '0;
            v_total = '0;
            v_qty = '0;
         end else begin
            v_status = ST_ROW;
            v_price = price_ff[ri];
            v_total = sum_ff[ri];
            v_qty = rq4;
         end
      end
   end

   // Exported view.
   assign o_status = v_status;
   assign o_price = v_price;
   assign o_total = v_total;
   assign o_qty = v_qty;
   assign o_last = v_last;
endmodule
`default_nettype wire

@@ rtl/core/order_book_side_levels.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Update: the item is captured on accept, applied to the table in the apply state, and the
// result is then held until taken; the next item is accepted only after the result leaves.
// Read: the read pointer is reset in the apply state, then one row per cycle while rsp_tready is high.
// Synchronous active-high reset empties the book and selects the ask side.
module order_book_side_levels
   import obsl_pkg::*;
#(
   parameter int BOOK_DEPTH = BookDepthDefault,
   parameter int EXCHANGES = ExchangesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // price[31:0], quantity[63:32], exchange_id[65:64], read_limit[70:66], zero fill
   input  wire logic [71:0]  req_tdata,
   input  wire logic         req_tuser,  // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], level_price[34:3], level_total[68:35], exch0..3 [196:69], zero fill
   output logic [199:0]      rsp_tdata,
   output logic              rsp_tlast
);
   logic desc_ff;
   always_ff @(posedge clock) begin
      if (reset) desc_ff <= 1'b0;
      else if (csr_we) desc_ff <= csr_wdata;
   end

   cmd_type cmd;
   stat_type stat;
   logic [2:0] st;
   logic [PriceW-1:0] pr;
   logic [SumW-1:0] tot;
   logic [3:0][QtyW-1:0] qv;
   logic lst;

   obsl_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_op(req_tuser), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd, .stat
   );

   obsl_datapath #(.BOOK_DEPTH(BOOK_DEPTH), .EXCHANGES(EXCHANGES)) u_dp (
      .clock, .reset, .desc(desc_ff),
      .in_price(req_tdata[31:0]), .in_qty(req_tdata[63:32]),
      .in_exch(req_tdata[65:64]), .in_limit(req_tdata[70:66]),
      .cmd, .stat, .o_status(st), .o_price(pr), .o_total(tot), .o_qty(qv), .o_last(lst)
   );

   assign rsp_tdata = {3'b000, qv[3], qv[2], qv[1], qv[0], tot, pr, st};
   assign rsp_tlast = lst;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import obsl_pkg::*;

   localparam int Depth = 16;
   localparam int Exch = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic rsp_tlast;

   order_book_side_levels dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [2:0] status;
      logic [31:0] price;
      logic [33:0] total;
      logic [3:0][31:0] qty;
      logic last;
   } level_report_type;

   // Local copy of the book.
   logic bid_side;
   logic [31:0] book_price [Depth];
   logic [31:0] book_qty [Depth][Exch];
   logic [33:0] book_sum [Depth];
   logic book_valid [Depth];

   level_report_type expected_reports [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic logic [33:0] sum_of_level(int r);
      logic [35:0] s;
      s = '0;
      for (int e = 0; e < Exch; e++) s += book_qty[r][e];
      return (s > SumMax) ? SumMax : s[33:0];
   endfunction

   function automatic level_report_type make_report(logic [2:0] st, logic [31:0] p, int r,
                                                    logic lst);
      level_report_type t;
      t = '0;
      t.status = st;
      t.price = p;
      t.last = lst;
      if (r >= 0) begin
         t.total = book_sum[r];
         for (int j = 0; j < 4; j++) t.qty[j] = (j < Exch) ? book_qty[r][j] : '0;
      end
      return t;
   endfunction

   task automatic clear_level(int r);
      book_valid[r] = 1'b0;
      book_price[r] = '0;
      book_sum[r] = '0;
      for (int e = 0; e < Exch; e++) book_qty[r][e] = '0;
   endtask

   task automatic copy_level(int dst, int src);
      book_valid[dst] = book_valid[src];
      book_price[dst] = book_price[src];
      book_sum[dst] = book_sum[src];
      for (int e = 0; e < Exch; e++) book_qty[dst][e] = book_qty[src][e];
   endtask

   task automatic predict_book(logic op, logic [31:0] p, logic [31:0] q, logic [1:0] ex,
                               logic [4:0] lim_in);
      int loc;
      int n;
      int lim;
      logic better;
      logic match;
      loc = Depth;
      if (op == OP_READ) begin
         lim = (lim_in > MaxOut) ? MaxOut : lim_in;
         if (lim > Depth) lim = Depth;
         n = 0;
         while (n < lim && book_valid[n]) n++;
         if (n == 0) expected_reports.push_back(make_report(ST_EMPTY, '0, -1, 1'b1));
         for (int k = 0; k < n; k++)
            expected_reports.push_back(make_report(ST_ROW, book_price[k], k, k == n - 1));
      end else if (ex >= Exch) begin
         expected_reports.push_back(make_report(ST_IGNORED, p, -1, 1'b1));
      end else begin
         for (int r = 0; r < Depth; r++) begin
            better = bid_side ? (book_price[r] > p) : (book_price[r] < p);
            if (!book_valid[r] || !better) begin
               loc = r;
               break;
            end
         end
         if (loc >= Depth) begin
            expected_reports.push_back(make_report(ST_PAST_END, p, -1, 1'b1));
         end else begin
            match = book_valid[loc] && book_price[loc] == p;
            if (!match && q != 0) begin
               for (int r = Depth - 1; r > loc; r--) copy_level(r, r - 1);
               clear_level(loc);
               book_valid[loc] = 1'b1;
               book_price[loc] = p;
               book_qty[loc][ex] = q;
               book_sum[loc] = sum_of_level(loc);
               expected_reports.push_back(make_report(ST_INSERTED, p, loc, 1'b1));
            end else if (match && q == 0) begin
               book_qty[loc][ex] = '0;
               book_sum[loc] = sum_of_level(loc);
               if (book_sum[loc] != 0) begin
                  expected_reports.push_back(make_report(ST_CLEARED, p, loc, 1'b1));
               end else begin
                  for (int r = loc; r + 1 < Depth; r++) copy_level(r, r + 1);
                  clear_level(Depth - 1);
                  expected_reports.push_back(make_report(ST_REMOVED, p, -1, 1'b1));
               end
            end else if (match) begin
               book_qty[loc][ex] = q;
               book_sum[loc] = sum_of_level(loc);
               expected_reports.push_back(make_report(ST_UPDATED, p, loc, 1'b1));
            end else begin
               expected_reports.push_back(make_report(ST_IGNORED, p, -1, 1'b1));
            end
         end
      end
   endtask

   // The block takes no new item until the last result has left, so tvalid is
   // dropped after each accept.
   task automatic send_item(logic op, logic [31:0] p, logic [31:0] q, logic [1:0] ex,
                            logic [4:0] lim);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, lim, ex, q, p};
      predict_book(op, p, q, ex, lim);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_update(logic [31:0] p, logic [31:0] q, logic [1:0] ex);
      send_item(OP_UPDATE, p, q, ex, 5'($urandom_range(31)));
   endtask

   task automatic send_read(logic [4:0] lim);
      send_item(OP_READ, $urandom, $urandom, 2'($urandom_range(3)), lim);
   endtask

   // An update yields exactly one result and a read at least one, so an empty queue means the block is idle.
   task automatic wait_drained();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_side(logic bid);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= bid;
      bid_side = bid;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset)
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      level_report_type got;
      level_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.price = rsp_tdata[34:3];
         got.total = rsp_tdata[68:35];
         got.qty = rsp_tdata[196:69];
         got.last = rsp_tlast;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            if (got.status !== want.status || got.price !== want.price ||
                got.total !== want.total || got.qty !== want.qty ||
                got.last !== want.last) begin
               $display("%0t: result mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   task automatic test_directed_ask();
      send_read(5'd4);
      send_update(32'd100, 32'd0, 2'd0);
      send_update(32'd100, 32'hFFFF_FFFF, 2'd0);
      send_update(32'd100, 32'hFFFF_FFFF, 2'd1);
      send_update(32'd100, 32'hFFFF_FFFF, 2'd2);
      send_update(32'd100, 32'hFFFF_FFFF, 2'd3);
      send_update(32'd0, 32'd5, 2'd3);
      send_update(32'hFFFF_FFFF, 32'd7, 2'd1);
      send_update(32'd50, 32'd0, 2'd2);
      send_update(32'd100, 32'd0, 2'd0);
      send_read(5'd0);
      send_read(5'd31);
      for (int i = 0; i < 16; i++) send_update(32'd200 + i, 32'd1 + i, 2'(i));
      send_update(32'hFFFF_FFFF, 32'd3, 2'd0);
      send_read(5'd16);
      send_update(32'd100, 32'd0, 2'd1);
      send_update(32'd100, 32'd0, 2'd2);
      send_update(32'd100, 32'd0, 2'd3);
      send_update(32'd0, 32'd0, 2'd3);
      send_read(5'd17);
   endtask

   task automatic test_random(int count, logic [31:0] base);
      logic [31:0] p;
      for (int i = 0; i < count; i++) begin
         p = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(24);
         case ($urandom_range(9))
            0, 1: send_update(p, 32'd0, 2'($urandom_range(3)));
            2: send_read(5'($urandom_range(31)));
            3: send_update(p, ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom,
                           2'($urandom_range(3)));
            default: send_update(p, $urandom_range(1000, 1), 2'($urandom_range(3)));
         endcase
      end
      send_read(5'd16);
   endtask

   task automatic test_bid_side();
      write_side(1'b1);
      send_update(32'd10, 32'd1, 2'd0);
      send_update(32'd30, 32'd2, 2'd1);
      send_update(32'd20, 32'd3, 2'd2);
      send_read(5'd16);
      test_random(50, 32'h8000_0000);
   endtask

   initial begin
      for (int r = 0; r < Depth; r++) clear_level(r);
      bid_side = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ask();
      test_random(50, 32'd190);
      send_idle_pct = 51;
      test_bid_side();
      send_idle_pct = 0;
      recv_stall_pct = 51;
      write_side(1'b0);
      test_random(50, 32'd1000);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      write_side(1'b1);
      test_random(50, 32'hFFFF_FFE0);
      write_side(1'b0);
      test_random(20, 32'd0);
      wait_drained();
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/obsl_pkg.sv
rtl/core/obsl_ctrl.sv
rtl/core/obsl_datapath.sv
rtl/core/order_book_side_levels.sv
tb/tb.sv
